// File: rtl/positional_list_store_unit_macros.svh
// Assertion macros used by the list store datapath.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef POSITIONAL_LIST_STORE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_STORE_UNIT_MACROS_SVH

// The condition holds at every clock edge.
`define PLS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PLS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pls_pkg.sv
`default_nettype none

package pls_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned LEN_W        = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                    command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
  } out_item_t;

  // Memory read address select.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_LAST,
    RD_POS_NEXT,
    RD_DOWN,
    RD_UP
  } rd_op_t;

  // Memory write select.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_VALUE,
    WR_SHIFT_UP,
    WR_SHIFT_DOWN
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    rd_op_t  rd_op;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    respond;
    logic    resp_ok;
    logic    resp_data;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t command;
    logic ins_ok;
    logic rem_ok;
    logic pos_at_end;
    logic pos_at_last;
    logic ins_walk_done;
    logic rem_walk_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/positional_list_store_unit.sv
// Channel      Ports                       Transaction taken when
// ----------   -------------------------   ------------------------------------
// command      start, busy, in_data        rising edge with start high, busy low
// result       out_valid, out_data         rising edge ending the out_valid cycle
//
// A clear, a failed command or an insert at the end is answered from the decode state; a read
// waits in S_READ_WAIT for the registered read port; inserts and removes that move entries walk
// them in S_INS_SHIFT (then S_INS_PUT) or S_REM_SHIFT. The entry memory has one write port and
// one registered read port and moves one entry per cycle. busy falls in the cycle the result is
// shown, so a new command may be taken at the edge that ends it. Reset is synchronous and
// active low and empties the list with no memory sweep; the receiver cannot stall a result.

`default_nettype none

module positional_list_store_unit #(
  parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pls_pkg::in_item_t in_data,
  output logic                   out_valid,
  output pls_pkg::out_item_t     out_data
);

  // The controller sequences each transaction; the datapath owns the entry
  // memory, the element count, the captured command and the result register.
  pls_pkg::dp_cmd_t  dp_cmd;
  pls_pkg::dp_stat_t dp_stat;

  pls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  // Inserts walk from the last entry down to the position, removes walk from
  // the entry after the position up to the end, each one entry per cycle.
  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/pls_datapath.sv
`default_nettype none

`include "positional_list_store_unit_macros.svh"

module pls_datapath #(
  parameter int unsigned CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pls_pkg::in_item_t   in_data,
  input  wire pls_pkg::dp_cmd_t    cmd,
  output pls_pkg::dp_stat_t        stat,
  output logic                     out_valid,
  output pls_pkg::out_item_t       out_data
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

  pls_pkg::in_item_t             item_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic [AW-1:0]                 rd_addr_r;
  logic signed [pls_pkg::VAL_W-1:0] rd_data_r;
  logic signed [pls_pkg::VAL_W-1:0] mem [CAPACITY];

  logic                          out_valid_r;
  pls_pkg::out_item_t            out_data_r;

  logic [CW-1:0]                 pos_cmp;
  logic [CW-1:0]                 cnt_cmp;
  logic [AW-1:0]                 pos_addr;
  logic [AW-1:0]                 last_addr;
  logic                          full;

  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic signed [pls_pkg::VAL_W-1:0] wr_data;

  assign pos_cmp   = CW'(item_r.position);
  assign cnt_cmp   = CW'(count_r);
  assign pos_addr  = AW'(item_r.position);
  assign last_addr = AW'(count_r - CNT_W'(1));
  assign full      = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    stat.command       = item_r.command;
    stat.ins_ok        = (pos_cmp <= cnt_cmp) && !full;
    stat.rem_ok        = (pos_cmp < cnt_cmp);
    stat.pos_at_end    = (pos_cmp == cnt_cmp);
    stat.pos_at_last   = ((pos_cmp + CW'(1)) == cnt_cmp);
    stat.ins_walk_done = (rd_addr_r == pos_addr);
    stat.rem_walk_done = ((CW'(rd_addr_r) + CW'(1)) == cnt_cmp);
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = rd_addr_r;
    case (cmd.rd_op)
      pls_pkg::RD_NONE:     rd_en   = 1'b0;
      pls_pkg::RD_POS:      rd_addr = pos_addr;
      pls_pkg::RD_LAST:     rd_addr = last_addr;
      pls_pkg::RD_POS_NEXT: rd_addr = pos_addr + AW'(1);
      pls_pkg::RD_DOWN:     rd_addr = rd_addr_r - AW'(1);
      pls_pkg::RD_UP:       rd_addr = rd_addr_r + AW'(1);
      default:              rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos_addr;
    wr_data = rd_data_r;
    case (cmd.wr_op)
      pls_pkg::WR_NONE:       wr_en   = 1'b0;
      pls_pkg::WR_VALUE:      wr_data = item_r.value;
      pls_pkg::WR_SHIFT_UP:   wr_addr = rd_addr_r + AW'(1);
      pls_pkg::WR_SHIFT_DOWN: wr_addr = rd_addr_r - AW'(1);
      default:                wr_en   = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      pls_pkg::CNT_HOLD:  count_nxt = count_r;
      pls_pkg::CNT_CLEAR: count_nxt = '0;
      pls_pkg::CNT_INC:   count_nxt = count_r + CNT_W'(1);
      pls_pkg::CNT_DEC:   count_nxt = count_r - CNT_W'(1);
      default:            count_nxt = count_r;
    endcase
  end

  // Entry storage: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.respond) begin
      out_data_r.ok         <= cmd.resp_ok;
      out_data_r.read_value <= cmd.resp_data ? rd_data_r : '0;
      out_data_r.length     <= pls_pkg::LEN_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.respond;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PLS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(CAPACITY), "element count above capacity")
  `PLS_ASSERT_IMPLY(a_port_conflict, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one entry")
  `PLS_ASSERT_IMPLY(a_count_with_resp, cmd.cnt_op != pls_pkg::CNT_HOLD, cmd.respond, "count moved without a result")
  `PLS_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r, "result strobe held two cycles")

endmodule

`default_nettype wire

// File: rtl/pls_ctrl.sv
`default_nettype none

module pls_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire pls_pkg::dp_stat_t stat,
  output pls_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_INS_SHIFT,
    S_INS_PUT,
    S_REM_SHIFT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.rd_op     = pls_pkg::RD_NONE;
    cmd.wr_op     = pls_pkg::WR_NONE;
    cmd.cnt_op    = pls_pkg::CNT_HOLD;
    cmd.respond   = 1'b0;
    cmd.resp_ok   = 1'b0;
    cmd.resp_data = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (stat.command)
          pls_pkg::CMD_CLEAR: begin
            cmd.cnt_op  = pls_pkg::CNT_CLEAR;
            cmd.respond = 1'b1;
            cmd.resp_ok = 1'b1;
          end
          pls_pkg::CMD_READ: begin
            if (stat.rem_ok) begin
              cmd.rd_op = pls_pkg::RD_POS;
              state_nxt = S_READ_WAIT;
            end else begin
              cmd.respond = 1'b1;
            end
          end
          pls_pkg::CMD_INSERT: begin
            if (!stat.ins_ok) begin
              cmd.respond = 1'b1;
            end else if (stat.pos_at_end) begin
              cmd.wr_op   = pls_pkg::WR_VALUE;
              cmd.cnt_op  = pls_pkg::CNT_INC;
              cmd.respond = 1'b1;
              cmd.resp_ok = 1'b1;
            end else begin
              cmd.rd_op = pls_pkg::RD_LAST;
              state_nxt = S_INS_SHIFT;
            end
          end
          pls_pkg::CMD_REMOVE: begin
            if (!stat.rem_ok) begin
              cmd.respond = 1'b1;
            end else if (stat.pos_at_last) begin
              cmd.cnt_op  = pls_pkg::CNT_DEC;
              cmd.respond = 1'b1;
              cmd.resp_ok = 1'b1;
            end else begin
              cmd.rd_op = pls_pkg::RD_POS_NEXT;
              state_nxt = S_REM_SHIFT;
            end
          end
          default: begin
            cmd.respond = 1'b1;
          end
        endcase
      end
      S_READ_WAIT: begin
        cmd.respond   = 1'b1;
        cmd.resp_ok   = 1'b1;
        cmd.resp_data = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_INS_SHIFT: begin
        // Move the entry read last cycle up by one; walk toward the position.
        cmd.wr_op = pls_pkg::WR_SHIFT_UP;
        if (stat.ins_walk_done) begin
          state_nxt = S_INS_PUT;
        end else begin
          cmd.rd_op = pls_pkg::RD_DOWN;
        end
      end
      S_INS_PUT: begin
        cmd.wr_op   = pls_pkg::WR_VALUE;
        cmd.cnt_op  = pls_pkg::CNT_INC;
        cmd.respond = 1'b1;
        cmd.resp_ok = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_REM_SHIFT: begin
        // Move the entry read last cycle down by one; walk toward the end.
        cmd.wr_op = pls_pkg::WR_SHIFT_DOWN;
        if (stat.rem_walk_done) begin
          cmd.cnt_op  = pls_pkg::CNT_DEC;
          cmd.respond = 1'b1;
          cmd.resp_ok = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_op = pls_pkg::RD_UP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

// Testbench for positional_list_store_unit, the ordered list store.
//
// A predictor holds its own copy of the list contents and the element count.
// It is updated at the clock edge that takes each command transaction, and the
// result it predicts is queued. Every strobed result from the block is checked
// against the oldest queued prediction, one field at a time. The directed table
// comes first, then random episodes that mix commands or fill the store to its
// limit and drain it again.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int LIST_DEPTH    = CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 900;
  localparam int QUIET_TAIL    = 150;       // The last commands go out back to back.
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int NUM_DIRECTED  = 25;

  // One row of the directed table. When typed_result is set, want is the
  // result written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    in_item_t  item;
    logic      typed_result;
    out_item_t want;
  } directed_row_t;

  // Each row reads: command, position, value, typed flag, ok, read value, length.
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // On an empty list, a read, a remove and an insert past the end all fail.
    {CMD_READ,   7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_REMOVE, 7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_INSERT, 7'd1,   32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000, 7'd0},
    // Build a list of three that holds the value extremes.
    {CMD_INSERT, 7'd0,   32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 7'd1},
    {CMD_INSERT, 7'd1,   32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000, 7'd2},
    {CMD_INSERT, 7'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 7'd3},
    // Inserts past the end fail and leave the list alone.
    {CMD_INSERT, 7'd4,   32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0000_0000, 7'd3},
    {CMD_INSERT, 7'd127, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0000_0000, 7'd3},
    {CMD_READ,   7'd0,   32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 7'd3},
    {CMD_READ,   7'd2,   32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, 7'd3},
    // Reads and removes at or past the count fail.
    {CMD_READ,   7'd3,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd3},
    {CMD_READ,   7'd127, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd3},
    {CMD_REMOVE, 7'd3,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd3},
    {CMD_REMOVE, 7'd127, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd3},
    // Append, insert in the middle, and remove at the head and the tail.
    {CMD_INSERT, 7'd3,   32'h55AA_55AA, 1'b0, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_INSERT, 7'd2,   32'hAAAA_5555, 1'b0, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_REMOVE, 7'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_READ,   7'd1,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_REMOVE, 7'd3,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_READ,   7'd2,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0},
    // Clear always succeeds, even on an empty list, and hides old entries.
    {CMD_CLEAR,  7'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 7'd0},
    {CMD_CLEAR,  7'd127, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 7'd0},
    {CMD_READ,   7'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 7'd0},
    {CMD_INSERT, 7'd0,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 7'd1},
    {CMD_READ,   7'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 7'd0}
  };

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  // Predictor state: the list contents and how many entries are in use.
  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int                      list_len;

  out_item_t expected_results [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  items_sent     = 0;
  int  rejected_count = 0;
  int  peak_len       = 0;
  int  full_hits      = 0;
  int  cmd_count [4]  = '{0, 0, 0, 0};
  bit  gaps_on        = 1'b1;
  int  gap_odds       = 4;   // A gap follows roughly one command in gap_odds.

  positional_list_store_unit #(
    .CAPACITY (LIST_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Predicts the result of one command and updates the list copy to match.
  // An insert shifts later entries up one place, a remove shifts them down.
  function automatic out_item_t apply_list_command(input in_item_t cmd);
    out_item_t res;
    int        k;
    int        pos;
    res = '0;
    pos = int'(cmd.position);
    case (cmd.command)
      CMD_INSERT: begin
        if (pos <= list_len && list_len < LIST_DEPTH) begin
          for (k = list_len; k > pos; k--)
            list_mem[k] = list_mem[k-1];
          list_mem[pos] = cmd.value;
          list_len++;
          res.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos < list_len) begin
          for (k = pos; k + 1 < list_len; k++)
            list_mem[k] = list_mem[k+1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos < list_len) begin
          res.ok         = 1'b1;
          res.read_value = list_mem[pos];
        end
      end
      default: begin
        list_len = 0;
        res.ok   = 1'b1;
      end
    endcase
    res.length = list_len[LEN_W-1:0];
    return res;
  endfunction

  // Offers one command and holds it until the block takes it. The predictor
  // runs at the very edge that takes the transaction, so it always sees the
  // list as the block does. start is written once per edge: when no gap
  // follows, it simply stays high for the next command.
  task automatic issue_command(input in_item_t cmd, input bit typed_result,
                               input out_item_t typed_want);
    out_item_t predicted;
    in_data <= cmd;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd.command == CMD_INSERT && list_len == LIST_DEPTH)
      full_hits++;
    predicted = apply_list_command(cmd);
    expected_results.push_back(typed_result ? typed_want : predicted);
    items_sent++;
    cmd_count[int'(cmd.command)]++;
    if (!predicted.ok)
      rejected_count++;
    if (list_len > peak_len)
      peak_len = list_len;
    if (gaps_on && $urandom_range(1, gap_odds) == 1) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Values lean on the extremes now and then; otherwise every bit is random.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly valid positions, with a share drawn from the whole 7-bit range so
  // that out-of-range positions and the high position bits are exercised.
  function automatic logic [POS_W-1:0] pick_position(input cmd_t op);
    if ($urandom_range(0, 9) == 0)
      return POS_W'($urandom_range(0, 127));
    if (op == CMD_INSERT)
      return POS_W'($urandom_range(0, list_len));
    if (list_len == 0)
      return '0;
    return POS_W'($urandom_range(0, list_len - 1));
  endfunction

  task automatic send_random(input cmd_t op);
    in_item_t cmd;
    cmd.command  = op;
    cmd.position = pick_position(op);
    cmd.value    = pick_value();
    issue_command(cmd, 1'b0, '0);
  endtask

  // A stretch of mixed commands. Inserts outnumber removes, so the list
  // tends to grow until a clear or a fill episode's drain brings it down.
  task automatic run_mixed_episode(input int n);
    int   pick;
    cmd_t op;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        op = CMD_INSERT;
      else if (pick < 70)
        op = CMD_REMOVE;
      else if (pick < 97)
        op = CMD_READ;
      else
        op = CMD_CLEAR;
      send_random(op);
    end
  endtask

  // Fills the store to capacity, hits it with inserts that must fail, reads
  // at the last slot and one beyond, then drains part or all of it again.
  task automatic run_fill_episode();
    in_item_t cmd;
    while (list_len < LIST_DEPTH)
      send_random(CMD_INSERT);
    repeat ($urandom_range(2, 4)) send_random(CMD_INSERT);
    cmd.command  = CMD_INSERT;
    cmd.position = POS_W'(LIST_DEPTH);
    cmd.value    = pick_value();
    issue_command(cmd, 1'b0, '0);
    cmd.command  = CMD_READ;
    cmd.position = POS_W'(LIST_DEPTH - 1);
    issue_command(cmd, 1'b0, '0);
    cmd.position = POS_W'(LIST_DEPTH);
    issue_command(cmd, 1'b0, '0);
    repeat ($urandom_range(1, LIST_DEPTH)) begin
      if ($urandom_range(0, 3) == 0)
        send_random(CMD_READ);
      else
        send_random(CMD_REMOVE);
    end
  endtask

  // Result checker. Outputs are sampled at the edge that ends the strobe
  // cycle, before the block's own updates at that edge take effect.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing awaited: ok %b value %h length %0d",
                                out_data.ok, out_data.read_value, out_data.length));
      end else begin
        want = expected_results.pop_front();
        if (out_data.ok !== want.ok)
          note_mismatch($sformatf("ok: expected %b, got %b", want.ok, out_data.ok));
        if (out_data.read_value !== want.read_value)
          note_mismatch($sformatf("read_value: expected %h, got %h",
                                  want.read_value, out_data.read_value));
        if (out_data.length !== want.length)
          note_mismatch($sformatf("length: expected %0d, got %0d",
                                  want.length, out_data.length));
      end
    end
  end

  initial begin : stimulus
    int target;
    list_len = 0;
    foreach (list_mem[k])
      list_mem[k] = '0;

    // Reset is held low from the start and then released for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: the hand-written rows pin down the obvious results,
    // the rest lean on the predictor.
    for (int r = 0; r < NUM_DIRECTED; r++)
      issue_command(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed_result,
                    DIRECTED_ROWS[r].want);

    // Random episodes. Each picks its own idling odds, so some run with
    // frequent gaps and some with none; the final stretch has no gaps at all.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      gaps_on  = (target - items_sent) > QUIET_TAIL && $urandom_range(0, 4) != 0;
      gap_odds = $urandom_range(2, 6);
      if ($urandom_range(0, 5) == 0)
        run_fill_episode();
      else
        run_mixed_episode($urandom_range(15, 40));
    end
    start <= 1'b0;

    // Drain: wait for every awaited result, then allow one worst-case command
    // time for anything stray to show up.
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);

    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("summary: %0d commands (insert %0d, remove %0d, read %0d, clear %0d)",
             items_sent, cmd_count[int'(CMD_INSERT)], cmd_count[int'(CMD_REMOVE)],
             cmd_count[int'(CMD_READ)], cmd_count[int'(CMD_CLEAR)]);
    $display("summary: %0d rejected, %0d inserts into a full store, peak length %0d,",
             rejected_count, full_hits, peak_len);
    $display("summary: %0d mismatches", mismatch_count);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
